### src/deq_pkg.sv
// Shared types and constants for the double-ended queue unit.
// Holds the request/response beat structs, opcodes, status codes and FSM state.
// No dependencies.
`default_nettype none

package deq_pkg;

  // Default geometry
  localparam int DEPTH_DEF     = 256;
  localparam int WORD_BITS_DEF = 32;

  // Request opcodes
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_REPLACE    = 3'd6
  } req_kind_t;

  // Response status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Request beat
  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] item_value;
    logic [7:0]  position;
  } req_t;

  // Response beat
  typedef struct packed {
    logic [31:0] result_value;
    logic [1:0]  status;
    logic [8:0]  fill_count;
  } rsp_t;

  // Controller state
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EXEC  = 2'd1,
    S_RDATA = 2'd2
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic emit_read;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic needs_read;
  } dp_stat_t;

endpackage

`default_nettype wire

### src/deq_ctrl.sv
// Request sequencer for the double-ended queue unit.
// Depends on deq_pkg for state, command and status types.
`default_nettype none

module deq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire deq_pkg::dp_stat_t  dp_stat,
  output deq_pkg::ctl_cmd_t       cmd,
  output logic                    busy
);

  deq_pkg::state_t state;
  deq_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= deq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    cmd.capture   = 1'b0;
    cmd.exec      = 1'b0;
    cmd.emit_read = 1'b0;
    busy          = 1'b1;
    case (state)
      deq_pkg::S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
        if (start) begin
          state_next = deq_pkg::S_EXEC;
        end
      end
      deq_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        if (dp_stat.needs_read) begin
          state_next = deq_pkg::S_RDATA;
        end else begin
          state_next = deq_pkg::S_IDLE;
        end
      end
      deq_pkg::S_RDATA: begin
        cmd.emit_read = 1'b1;
        state_next    = deq_pkg::S_IDLE;
      end
      default: begin
        state_next = deq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/deq_dpath.sv
// Datapath of the double-ended queue unit: entry memory, front pointer,
// entry count and the response register. Depends on deq_pkg.
`default_nettype none

module deq_dpath #(
  parameter int DEPTH     = deq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = deq_pkg::WORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire deq_pkg::req_t      req,
  input  wire deq_pkg::ctl_cmd_t  cmd,
  output deq_pkg::dp_stat_t       dp_stat,
  output logic                    done,
  output deq_pkg::rsp_t           rsp
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 8) ? CW : 8;

  // Captured request
  deq_pkg::req_t        req_q;
  deq_pkg::req_kind_t   kind;
  logic [WORD_BITS-1:0] word;

  // Queue state
  logic [PW-1:0] front;
  logic [PW-1:0] front_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  // Operation decode
  logic          is_empty;
  logic          is_full;
  logic          in_range;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [CW-1:0] sel_off;
  logic [CW:0]   slot_sum;
  logic [CW:0]   slot_wrap;
  logic [PW-1:0] slot;
  logic [PW-1:0] front_dec;
  logic [PW-1:0] front_inc;
  logic          use_dec;
  logic [PW-1:0] mem_addr;
  logic          wr_op;
  logic          rd_op;
  logic [31:0]   val;
  deq_pkg::status_t stat;

  // Entry memory
  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata;

  // Held status for a read response
  logic [1:0] pend_stat;
  logic [8:0] pend_fill;

  assign kind     = deq_pkg::req_kind_t'(req_q.req_type);
  assign word     = WORD_BITS'(req_q.item_value);
  assign is_empty = (count == '0);
  assign is_full  = (count == CW'(DEPTH));
  assign pos_x    = XW'(req_q.position);
  assign cnt_x    = XW'(count);
  assign in_range = (pos_x < cnt_x);

  // Wrap front + offset into the store, one compare and subtract
  assign slot_sum  = (CW+1)'(front) + (CW+1)'(sel_off);
  assign slot_wrap = (slot_sum >= (CW+1)'(DEPTH)) ? slot_sum - (CW+1)'(DEPTH) : slot_sum;
  assign slot      = slot_wrap[PW-1:0];

  assign front_dec = (front == '0) ? PW'(DEPTH - 1) : front - 1'b1;
  assign front_inc = (front == PW'(DEPTH - 1)) ? '0 : front + 1'b1;
  assign mem_addr  = use_dec ? front_dec : slot;

  // Decode the captured request
  always_comb begin
    sel_off    = '0;
    use_dec    = 1'b0;
    wr_op      = 1'b0;
    rd_op      = 1'b0;
    front_next = front;
    count_next = count;
    val        = '0;
    stat       = deq_pkg::ST_OK;
    case (kind)
      deq_pkg::OP_PUSH_FRONT: begin
        if (is_full) begin
          stat = deq_pkg::ST_FULL;
        end else begin
          use_dec    = 1'b1;
          wr_op      = 1'b1;
          front_next = front_dec;
          count_next = count + 1'b1;
          val        = 32'(word);
        end
      end
      deq_pkg::OP_PUSH_BACK: begin
        sel_off = count;
        if (is_full) begin
          stat = deq_pkg::ST_FULL;
        end else begin
          wr_op      = 1'b1;
          count_next = count + 1'b1;
          val        = 32'(word);
        end
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_PEEK_FRONT: begin
        if (is_empty) begin
          stat = deq_pkg::ST_EMPTY;
        end else begin
          rd_op = 1'b1;
          if (kind == deq_pkg::OP_POP_FRONT) begin
            front_next = front_inc;
            count_next = count - 1'b1;
          end
        end
      end
      deq_pkg::OP_POP_BACK, deq_pkg::OP_PEEK_BACK: begin
        sel_off = count - 1'b1;
        if (is_empty) begin
          stat = deq_pkg::ST_EMPTY;
        end else begin
          rd_op = 1'b1;
          if (kind == deq_pkg::OP_POP_BACK) begin
            count_next = count - 1'b1;
          end
        end
      end
      deq_pkg::OP_REPLACE: begin
        if (in_range) begin
          sel_off = pos_x[CW-1:0];
          wr_op   = 1'b1;
          val     = 32'(word);
        end else begin
          sel_off = count;
          if (is_full) begin
            stat = deq_pkg::ST_FULL;
          end else begin
            wr_op      = 1'b1;
            count_next = count + 1'b1;
            val        = 32'(word);
          end
        end
      end
      default: begin
        stat = deq_pkg::ST_OK;
      end
    endcase
  end

  assign dp_stat.needs_read = rd_op;

  // Capture the request beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
  end

  // Memory port: one write or one registered read per request
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_op) begin
      mem[mem_addr] <= word;
    end
    if (cmd.exec && rd_op) begin
      rdata <= mem[mem_addr];
    end
  end

  // Advance queue pointers and raise the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (cmd.exec && !rd_op) || cmd.emit_read;
      if (cmd.exec) begin
        front <= front_next;
        count <= count_next;
      end
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pend_stat <= stat;
      pend_fill <= 9'(count_next);
      if (!rd_op) begin
        rsp.result_value <= val;
        rsp.status       <= stat;
        rsp.fill_count   <= 9'(count_next);
      end
    end
    if (cmd.emit_read) begin
      rsp.result_value <= 32'(rdata);
      rsp.status       <= pend_stat;
      rsp.fill_count   <= pend_fill;
    end
  end

endmodule

`default_nettype wire

### src/double_ended_queue_with_replace_unit.sv
// Top level of the double-ended queue unit with replace-at-index.
// Instantiates deq_ctrl and deq_dpath; types come from deq_pkg.
//
// A request beat is taken when start is high and busy is low. Every request
// answers with exactly one response beat, shown on rsp for a single cycle
// while done is high; the receiver cannot stall it, so it must take it then.
// Push, replace, errors and the unused opcode answer from the execute state;
// a pop or peek that succeeds also passes the read state, for the registered
// read of the single-port entry memory. busy drops in the cycle that done
// rises, so a new request may be accepted alongside it. The memory has no
// reset or clearing pass: only entries within the count are ever read.
`default_nettype none

module double_ended_queue_with_replace_unit #(
  parameter int DEPTH     = deq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = deq_pkg::WORD_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire deq_pkg::req_t req,
  output logic               busy,
  output logic               done,
  output deq_pkg::rsp_t      rsp
);

  deq_pkg::ctl_cmd_t cmd;
  deq_pkg::dp_stat_t dp_stat;

  // Sequencer
  deq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .dp_stat (dp_stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  // Storage and response path
  deq_dpath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .cmd     (cmd),
    .dp_stat (dp_stat),
    .done    (done),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire

### src/deq_chk.sv
// Port-level checker for the double-ended queue unit, bound to the top level.
// Depends on deq_pkg for the beat and status types.
`default_nettype none

module deq_chk (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done,
  input wire deq_pkg::rsp_t  rsp
);

  // An accepted beat makes the unit busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("unit not busy after accepting a request");

  // A response never shows up in the cycle right after an accept
  a_no_early_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("response strobe too early after accept");

  // A response is only shown while the unit is idle again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("response strobe while busy");

  // Errors return a zero word
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != deq_pkg::ST_OK) |-> (rsp.result_value == '0))
    else $error("error response carries a nonzero word");

  // An empty error only occurs on an empty queue
  a_empty_fill: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == deq_pkg::ST_EMPTY) |-> (rsp.fill_count == '0))
    else $error("empty error with nonzero fill count");

endmodule

bind double_ended_queue_with_replace_unit deq_chk u_deq_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

`default_nettype wire

### test/double_ended_queue_with_replace_unit_tb.sv
// Self-checking testbench for double_ended_queue_with_replace_unit.
// Runs a directed table, then random grow/drain traffic checked by a local deque predictor.
// Depends on deq_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module double_ended_queue_with_replace_unit_tb;

  localparam int DEPTH = deq_pkg::DEPTH_DEF;
  localparam int RAND_ITEMS = 900;
  localparam int PHASE_ITEMS = RAND_ITEMS / 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 10;
  localparam int REPORT_MAX = 10;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef enum logic {GROW, DRAIN} trend_t;

  // One directed row: the beat and, where fixed, its expected response
  typedef struct packed {
    deq_pkg::req_t beat;
    logic fixed;
    deq_pkg::rsp_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  deq_pkg::req_t req = '0;
  logic busy;
  logic done;
  deq_pkg::rsp_t rsp;

  // Predictor state
  logic [31:0] shadow_words [0:DEPTH-1];
  int shadow_head = 0;
  int shadow_level = 0;
  int peak_level = 0;

  deq_pkg::rsp_t pending_rsp [$];
  int cycle_cnt = 0;
  int mismatch_cnt = 0;
  int beats_seen = 0;
  int items_sent = 0;
  int empty_seen = 0;
  int full_seen = 0;

  double_ended_queue_with_replace_unit u_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Advance the deque predictor by one beat and return its response
  function automatic deq_pkg::rsp_t deque_respond(input deq_pkg::req_t beat);
    deq_pkg::rsp_t r;
    int slot;
    r.result_value = '0;
    r.status = deq_pkg::ST_OK;
    case (beat.req_type)
      deq_pkg::OP_PUSH_FRONT: begin
        if (shadow_level == DEPTH) begin
          r.status = deq_pkg::ST_FULL;
        end else begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_words[shadow_head] = beat.item_value;
          shadow_level++;
          r.result_value = beat.item_value;
        end
      end
      deq_pkg::OP_PUSH_BACK, deq_pkg::OP_REPLACE: begin
        if (beat.req_type == deq_pkg::OP_REPLACE &&
            int'(beat.position) < shadow_level) begin
          // overwrite in place, count unchanged
          slot = (shadow_head + int'(beat.position)) % DEPTH;
          shadow_words[slot] = beat.item_value;
          r.result_value = beat.item_value;
        end else if (shadow_level == DEPTH) begin
          r.status = deq_pkg::ST_FULL;
        end else begin
          slot = (shadow_head + shadow_level) % DEPTH;
          shadow_words[slot] = beat.item_value;
          shadow_level++;
          r.result_value = beat.item_value;
        end
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_PEEK_FRONT: begin
        if (shadow_level == 0) begin
          r.status = deq_pkg::ST_EMPTY;
        end else begin
          r.result_value = shadow_words[shadow_head];
          if (beat.req_type == deq_pkg::OP_POP_FRONT) begin
            shadow_head = (shadow_head + 1) % DEPTH;
            shadow_level--;
          end
        end
      end
      deq_pkg::OP_POP_BACK, deq_pkg::OP_PEEK_BACK: begin
        if (shadow_level == 0) begin
          r.status = deq_pkg::ST_EMPTY;
        end else begin
          slot = (shadow_head + shadow_level - 1) % DEPTH;
          r.result_value = shadow_words[slot];
          if (beat.req_type == deq_pkg::OP_POP_BACK) shadow_level--;
        end
      end
      default: begin
      end
    endcase
    if (shadow_level > peak_level) peak_level = shadow_level;
    r.fill_count = shadow_level[8:0];
    return r;
  endfunction

  function automatic dir_row_t row(input logic [2:0] kind, input logic [31:0] word,
                                   input logic [7:0] pos, input logic fixed,
                                   input logic [31:0] rv, input logic [1:0] st,
                                   input logic [8:0] fc);
    dir_row_t d;
    d.beat.req_type = kind;
    d.beat.item_value = word;
    d.beat.position = pos;
    d.fixed = fixed;
    d.want.result_value = rv;
    d.want.status = st;
    d.want.fill_count = fc;
    return d;
  endfunction

  // Pick a data word, leaning on the extremes now and then
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 11))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Build one random beat; the trend keeps the deque sweeping between empty and full
  function automatic deq_pkg::req_t pick_beat(input trend_t trend);
    deq_pkg::req_t b;
    int roll;
    roll = $urandom_range(0, 99);
    b.item_value = pick_word();
    b.position = 8'($urandom);
    if (trend == GROW) begin
      if (roll < 40) b.req_type = deq_pkg::OP_PUSH_BACK;
      else if (roll < 75) b.req_type = deq_pkg::OP_PUSH_FRONT;
      else if (roll < 88) b.req_type = deq_pkg::OP_REPLACE;
      else if (roll < 92)
        b.req_type = (roll[0]) ? deq_pkg::OP_PEEK_FRONT : deq_pkg::OP_PEEK_BACK;
      else if (roll < 97)
        b.req_type = (roll[0]) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
      else b.req_type = OP_UNUSED;
    end else begin
      if (roll < 35) b.req_type = deq_pkg::OP_POP_FRONT;
      else if (roll < 70) b.req_type = deq_pkg::OP_POP_BACK;
      else if (roll < 80)
        b.req_type = (roll[0]) ? deq_pkg::OP_PEEK_FRONT : deq_pkg::OP_PEEK_BACK;
      else if (roll < 90) b.req_type = deq_pkg::OP_REPLACE;
      else if (roll < 95)
        b.req_type = (roll[0]) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
      else b.req_type = OP_UNUSED;
    end
    // when bit 1 of the roll is set, aim replace positions inside the count or at or past it
    if (b.req_type == deq_pkg::OP_REPLACE && roll[1]) begin
      if (shadow_level > 0 && roll[2])
        b.position = 8'($urandom_range(0, shadow_level - 1));
      else if (shadow_level < DEPTH)
        b.position = 8'($urandom_range(shadow_level, DEPTH - 1));
    end
    return b;
  endfunction

  // Present one beat from a falling edge, hold it until taken, queue its response
  task automatic issue(input deq_pkg::req_t beat, input logic fixed,
                       input deq_pkg::rsp_t want);
    deq_pkg::rsp_t predicted;
    start <= 1'b1;
    req <= beat;
    do begin
      @(posedge clk);
    end while (busy);
    predicted = deque_respond(beat);
    pending_rsp.push_back(fixed ? want : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  // Check each response beat against the oldest expectation
  always @(posedge clk) begin
    deq_pkg::rsp_t want;
    if (!rst && done) begin
      beats_seen++;
      if (rsp.status == deq_pkg::ST_EMPTY) empty_seen++;
      if (rsp.status == deq_pkg::ST_FULL) full_seen++;
      if (pending_rsp.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("[%0t] unexpected response: value=%h status=%0d count=%0d",
                   $realtime, rsp.result_value, rsp.status, rsp.fill_count);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.result_value !== want.result_value || rsp.status !== want.status ||
            rsp.fill_count !== want.fill_count) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display({"[%0t] mismatch: exp value=%h status=%0d count=%0d, ",
                      "got value=%h status=%0d count=%0d"},
                     $realtime, want.result_value, want.status, want.fill_count,
                     rsp.result_value, rsp.status, rsp.fill_count);
        end
      end
    end
  end

  // Stop a hung run
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    dir_row_t dir_rows [0:21];
    trend_t trend;
    int full_hits;
    int empty_hits;
    int idle_pct;
    deq_pkg::req_t beat;

    dir_rows = '{
      // empty deque: every read reports empty, unused opcode is a no-op
      row(deq_pkg::OP_POP_FRONT,  32'h0000_0000, 8'h00, 1'b1, 32'h0,
          deq_pkg::ST_EMPTY, 9'd0),
      row(deq_pkg::OP_POP_BACK,   32'hFFFF_FFFF, 8'hFF, 1'b1, 32'h0,
          deq_pkg::ST_EMPTY, 9'd0),
      row(deq_pkg::OP_PEEK_FRONT, 32'hFFFF_FFFF, 8'h00, 1'b1, 32'h0,
          deq_pkg::ST_EMPTY, 9'd0),
      row(deq_pkg::OP_PEEK_BACK,  32'h0000_0000, 8'hFF, 1'b1, 32'h0,
          deq_pkg::ST_EMPTY, 9'd0),
      row(OP_UNUSED,              32'hFFFF_FFFF, 8'hFF, 1'b1, 32'h0,
          deq_pkg::ST_OK, 9'd0),
      // extremes of the word, front pointer wraps below zero
      row(deq_pkg::OP_PUSH_BACK,  32'hFFFF_FFFF, 8'h00, 1'b1, 32'hFFFF_FFFF,
          deq_pkg::ST_OK, 9'd1),
      row(deq_pkg::OP_PUSH_FRONT, 32'h0000_0000, 8'hFF, 1'b1, 32'h0000_0000,
          deq_pkg::ST_OK, 9'd2),
      // replace far past the count appends
      row(deq_pkg::OP_REPLACE,    32'hA5A5_A5A5, 8'hFF, 1'b1, 32'hA5A5_A5A5,
          deq_pkg::ST_OK, 9'd3),
      // replace at the front overwrites
      row(deq_pkg::OP_REPLACE,    32'h1234_5678, 8'h00, 1'b1, 32'h1234_5678,
          deq_pkg::ST_OK, 9'd3),
      row(deq_pkg::OP_PEEK_FRONT, 32'h0, 8'h00, 1'b0, '0, deq_pkg::ST_OK, '0),
      row(deq_pkg::OP_PEEK_BACK,  32'h0, 8'h00, 1'b0, '0, deq_pkg::ST_OK, '0),
      // replace exactly at the count appends
      row(deq_pkg::OP_REPLACE,    32'hDEAD_BEEF, 8'h03, 1'b0, '0, deq_pkg::ST_OK, '0),
      row(deq_pkg::OP_REPLACE,    32'h5A5A_5A5A, 8'h01, 1'b0, '0, deq_pkg::ST_OK, '0),
      row(OP_UNUSED,              32'h0000_0000, 8'h00, 1'b0, '0, deq_pkg::ST_OK, '0),
      row(deq_pkg::OP_POP_BACK,   32'h0, 8'h00, 1'b0, '0, deq_pkg::ST_OK, '0),
      row(deq_pkg::OP_POP_FRONT,  32'h0, 8'h00, 1'b0, '0, deq_pkg::ST_OK, '0),
      row(deq_pkg::OP_POP_FRONT,  32'h0, 8'h00, 1'b0, '0, deq_pkg::ST_OK, '0),
      row(deq_pkg::OP_POP_BACK,   32'h0, 8'h00, 1'b0, '0, deq_pkg::ST_OK, '0),
      row(deq_pkg::OP_POP_BACK,   32'h0, 8'h00, 1'b1, 32'h0, deq_pkg::ST_EMPTY, 9'd0),
      row(deq_pkg::OP_PUSH_FRONT, 32'h8000_0001, 8'h80, 1'b0, '0, deq_pkg::ST_OK, '0),
      row(deq_pkg::OP_PEEK_BACK,  32'h0, 8'h00, 1'b0, '0, deq_pkg::ST_OK, '0),
      row(deq_pkg::OP_POP_FRONT,  32'h0, 8'h00, 1'b0, '0, deq_pkg::ST_OK, '0)
    };

    // Hold reset, then release it on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table back to back
    foreach (dir_rows[i]) issue(dir_rows[i].beat, dir_rows[i].fixed, dir_rows[i].want);

    // Random traffic in three phases of sender idling: 18%, 52%, none
    trend = GROW;
    full_hits = 0;
    empty_hits = 0;
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 18 : (phase == 1) ? 52 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // flip the trend once the deque has sat at an extreme for a while
        if (trend == GROW && shadow_level == DEPTH) full_hits++;
        if (trend == DRAIN && shadow_level == 0) empty_hits++;
        if (trend == GROW && full_hits >= 6) begin
          trend = DRAIN;
          full_hits = 0;
        end else if (trend == DRAIN && empty_hits >= 6) begin
          trend = GROW;
          empty_hits = 0;
        end
        beat = pick_beat(trend);
        if ($urandom_range(1, 100) <= idle_pct) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        issue(beat, 1'b0, '0);
      end
      // drain every outstanding response before the next phase
      start <= 1'b0;
      @(negedge clk);
      while (pending_rsp.size() != 0) @(negedge clk);
    end

    // Let any stray response show up
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests, %0d responses (%0d empty, %0d full errors),",
             items_sent, beats_seen, empty_seen, full_seen);
    $display("peak fill %0d of %0d.", peak_level, DEPTH);
    if (mismatch_cnt == 0 && pending_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d responses missing", mismatch_cnt, pending_rsp.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
src/deq_pkg.sv
src/deq_ctrl.sv
src/deq_dpath.sv
src/double_ended_queue_with_replace_unit.sv
src/deq_chk.sv
test/double_ended_queue_with_replace_unit_tb.sv
